[hdl/segx2d_pkg.sv]
package segx2d_pkg;

   localparam int CoordW = 16;
   localparam int DiffW  = CoordW + 1;
   localparam int ProdW  = 2 * DiffW;
   localparam int CrossW = ProdW + 1;
   localparam int SumW   = CrossW + 1;
   localparam int TolW   = 32;
   localparam int QuotW  = DiffW;
   localparam int NumW   = CrossW + QuotW;

   typedef enum logic [1:0] {
      KIND_MISS  = 2'd0,
      KIND_CROSS = 2'd1,
      KIND_AT_A  = 2'd2,
      KIND_AT_B  = 2'd3
   } kind_type;

   typedef struct packed {
      logic signed [CoordW-1:0] ax, ay, bx, by, cx, cy;
      logic signed [DiffW-1:0]  abx, aby, cdx, cdy, acx, acy;
   } s1_type;

   typedef struct packed {
      logic signed [CoordW-1:0] ax, ay, bx, by, cx, cy;
      logic signed [DiffW-1:0]  cdx, cdy;
      logic signed [ProdW-1:0]  abx_cdy, aby_cdx, acx_cdy, acy_cdx, acx_aby, acy_abx;
      logic signed [ProdW-1:0]  abx_abx, aby_aby, cdx_abx, cdy_aby, acx_abx, acy_aby;
   } s2_type;

   typedef struct packed {
      logic signed [CoordW-1:0] ax, ay, bx, by, cx, cy;
      logic signed [DiffW-1:0]  cdx, cdy;
      logic signed [CrossW-1:0] den, tn, un, len2, dir, lo;
   } s3_type;

   typedef struct packed {
      logic signed [CoordW-1:0] ax, ay, bx, by, cx, cy;
      logic signed [DiffW-1:0]  cdx, cdy;
      logic [CrossW-1:0]        aden, aun;
      logic signed [CrossW-1:0] tnp, unp;
      logic signed [SumW-1:0]   len2, lo, hi;
      logic                     dir_neg;
   } s4_type;

   typedef struct packed {
      logic                     hit;
      kind_type                 kind;
      logic signed [CoordW-1:0] px, py, cx, cy;
      logic [CrossW-1:0]        den, unm;
      logic [QuotW-1:0]         magx, magy;
      logic                     negx, negy;
   } s5_type;

   typedef struct packed {
      logic                     hit;
      kind_type                 kind;
      logic signed [CoordW-1:0] px, py, cx, cy;
      logic [CrossW-1:0]        den;
      logic [NumW-1:0]          remx, remy;
      logic [QuotW-1:0]         qx, qy;
      logic [QuotW-1:0]         magx, magy;
      logic                     negx, negy;
   } div_type;

endpackage

[hdl/segment_intersect_2d.sv]
// An accepted request transaction reaches rsp_tvalid through six arithmetic stages,
// 17 divider stages (one quotient bit per stage) and one output register.
// Throughput: one transaction per cycle; the pipeline advances whenever the output
// register is empty or being taken, so a held result stalls every stage in place.
// Reset (synchronous, active high) clears all valid bits and the tolerance to zero.
module segment_intersect_2d (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // ax, ay, bx, by, cx, cy, dx, dy
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // point_x, point_y
   output logic [2:0]   rsp_tuser    // hit, kind
);

   localparam int CW = segx2d_pkg::CoordW;
   localparam int DW = segx2d_pkg::DiffW;
   localparam int XW = segx2d_pkg::CrossW;
   localparam int SW = segx2d_pkg::SumW;
   localparam int QW = segx2d_pkg::QuotW;
   localparam int NW = segx2d_pkg::NumW;

   logic [segx2d_pkg::TolW-1:0] tol_ff;
   logic                        en;

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff;
   segx2d_pkg::s1_type  s1_ff, s1_in;
   segx2d_pkg::s2_type  s2_ff, s2_in;
   segx2d_pkg::s3_type  s3_ff, s3_in;
   segx2d_pkg::s4_type  s4_ff, s4_in;
   segx2d_pkg::s5_type  s5_ff, s5_in;
   segx2d_pkg::div_type s6_ff, s6_in;
   segx2d_pkg::div_type div_ff [QW];
   segx2d_pkg::div_type div_in [QW];
   logic [QW-1:0]       div_vld_ff;

   logic                rsp_tvalid_ff;
   logic [31:0]         rsp_tdata_ff, rsp_tdata_in;
   logic [2:0]          rsp_tuser_ff, rsp_tuser_in;

   function automatic segx2d_pkg::div_type div_step(segx2d_pkg::div_type d, int k);
      segx2d_pkg::div_type r;
      logic [NW-1:0]       dsh;
      r   = d;
      dsh = NW'(d.den) << k;
      if (d.remx >= dsh) begin
         r.remx  = d.remx - dsh;
         r.qx[k] = 1'b1;
      end
      if (d.remy >= dsh) begin
         r.remy  = d.remy - dsh;
         r.qy[k] = 1'b1;
      end
      return r;
   endfunction

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // Stage 1: edge vectors.
   always_comb begin
      logic signed [CW-1:0] dx, dy;
      s1_in.ax  = $signed(req_tdata[15:0]);
      s1_in.ay  = $signed(req_tdata[31:16]);
      s1_in.bx  = $signed(req_tdata[47:32]);
      s1_in.by  = $signed(req_tdata[63:48]);
      s1_in.cx  = $signed(req_tdata[79:64]);
      s1_in.cy  = $signed(req_tdata[95:80]);
      dx        = $signed(req_tdata[111:96]);
      dy        = $signed(req_tdata[127:112]);
      s1_in.abx = DW'(s1_in.bx) - DW'(s1_in.ax);
      s1_in.aby = DW'(s1_in.by) - DW'(s1_in.ay);
      s1_in.cdx = DW'(dx) - DW'(s1_in.cx);
      s1_in.cdy = DW'(dy) - DW'(s1_in.cy);
      s1_in.acx = DW'(s1_in.cx) - DW'(s1_in.ax);
      s1_in.acy = DW'(s1_in.cy) - DW'(s1_in.ay);
   end

   // Stage 2: all partial products of the cross and dot products.
   always_comb begin
      s2_in.ax = s1_ff.ax; s2_in.ay = s1_ff.ay;
      s2_in.bx = s1_ff.bx; s2_in.by = s1_ff.by;
      s2_in.cx = s1_ff.cx; s2_in.cy = s1_ff.cy;
      s2_in.cdx = s1_ff.cdx; s2_in.cdy = s1_ff.cdy;
      s2_in.abx_cdy = s1_ff.abx * s1_ff.cdy;
      s2_in.aby_cdx = s1_ff.aby * s1_ff.cdx;
      s2_in.acx_cdy = s1_ff.acx * s1_ff.cdy;
      s2_in.acy_cdx = s1_ff.acy * s1_ff.cdx;
      s2_in.acx_aby = s1_ff.acx * s1_ff.aby;
      s2_in.acy_abx = s1_ff.acy * s1_ff.abx;
      s2_in.abx_abx = s1_ff.abx * s1_ff.abx;
      s2_in.aby_aby = s1_ff.aby * s1_ff.aby;
      s2_in.cdx_abx = s1_ff.cdx * s1_ff.abx;
      s2_in.cdy_aby = s1_ff.cdy * s1_ff.aby;
      s2_in.acx_abx = s1_ff.acx * s1_ff.abx;
      s2_in.acy_aby = s1_ff.acy * s1_ff.aby;
   end

   // Stage 3: cross and dot products.
   always_comb begin
      s3_in.ax = s2_ff.ax; s3_in.ay = s2_ff.ay;
      s3_in.bx = s2_ff.bx; s3_in.by = s2_ff.by;
      s3_in.cx = s2_ff.cx; s3_in.cy = s2_ff.cy;
      s3_in.cdx = s2_ff.cdx; s3_in.cdy = s2_ff.cdy;
      s3_in.den  = XW'(s2_ff.abx_cdy) - XW'(s2_ff.aby_cdx);
      s3_in.tn   = XW'(s2_ff.acx_cdy) - XW'(s2_ff.acy_cdx);
      s3_in.un   = XW'(s2_ff.acx_aby) - XW'(s2_ff.acy_abx);
      s3_in.len2 = XW'(s2_ff.abx_abx) + XW'(s2_ff.aby_aby);
      s3_in.dir  = XW'(s2_ff.cdx_abx) + XW'(s2_ff.cdy_aby);
      s3_in.lo   = XW'(s2_ff.acx_abx) + XW'(s2_ff.acy_aby);
   end

   // Stage 4: magnitudes, sign normalization and the far projection.
   always_comb begin
      logic neg;
      s4_in.ax = s3_ff.ax; s4_in.ay = s3_ff.ay;
      s4_in.bx = s3_ff.bx; s4_in.by = s3_ff.by;
      s4_in.cx = s3_ff.cx; s4_in.cy = s3_ff.cy;
      s4_in.cdx = s3_ff.cdx; s4_in.cdy = s3_ff.cdy;
      neg          = s3_ff.den[XW-1];
      s4_in.aden   = neg ? $unsigned(-s3_ff.den) : $unsigned(s3_ff.den);
      s4_in.aun    = s3_ff.un[XW-1] ? $unsigned(-s3_ff.un) : $unsigned(s3_ff.un);
      s4_in.tnp    = neg ? -s3_ff.tn : s3_ff.tn;
      s4_in.unp    = neg ? -s3_ff.un : s3_ff.un;
      s4_in.len2   = SW'(s3_ff.len2);
      s4_in.lo     = SW'(s3_ff.lo);
      s4_in.hi     = SW'(s3_ff.lo) + SW'(s3_ff.dir);
      s4_in.dir_neg = s3_ff.dir[XW-1];
   end

   // Stage 5: classification.
   always_comb begin
      logic [XW-1:0]        tol;
      logic signed [SW-1:0] plo, phi;
      logic                 par, col, ovl, crs;
      tol  = XW'(tol_ff);
      plo  = s4_ff.dir_neg ? s4_ff.hi : s4_ff.lo;
      phi  = s4_ff.dir_neg ? s4_ff.lo : s4_ff.hi;
      par  = s4_ff.aden <= tol;
      col  = s4_ff.aun <= tol;
      ovl  = !(s4_ff.len2 < plo) && !(phi < SW'(0));
      crs  = !s4_ff.tnp[XW-1] && ($unsigned(s4_ff.tnp) <= s4_ff.aden)
          && !s4_ff.unp[XW-1] && ($unsigned(s4_ff.unp) <= s4_ff.aden);
      s5_in.hit  = 1'b0;
      s5_in.kind = segx2d_pkg::KIND_MISS;
      s5_in.px   = '0;
      s5_in.py   = '0;
      if (par) begin
         if (col && ovl) begin
            s5_in.hit = 1'b1;
            if (plo <= SW'(0)) begin
               s5_in.kind = segx2d_pkg::KIND_AT_A;
               s5_in.px   = s4_ff.ax;
               s5_in.py   = s4_ff.ay;
            end else begin
               s5_in.kind = segx2d_pkg::KIND_AT_B;
               s5_in.px   = s4_ff.bx;
               s5_in.py   = s4_ff.by;
            end
         end
      end else if (crs) begin
         s5_in.hit  = 1'b1;
         s5_in.kind = segx2d_pkg::KIND_CROSS;
      end
      s5_in.cx   = s4_ff.cx;
      s5_in.cy   = s4_ff.cy;
      s5_in.den  = s4_ff.aden;
      s5_in.unm  = $unsigned(s4_ff.unp);
      s5_in.negx = s4_ff.cdx[DW-1];
      s5_in.negy = s4_ff.cdy[DW-1];
      s5_in.magx = s4_ff.cdx[DW-1] ? $unsigned(-s4_ff.cdx) : $unsigned(s4_ff.cdx);
      s5_in.magy = s4_ff.cdy[DW-1] ? $unsigned(-s4_ff.cdy) : $unsigned(s4_ff.cdy);
   end

   // Stage 6: dividends of the crossing offsets.
   always_comb begin
      s6_in.hit  = s5_ff.hit;
      s6_in.kind = s5_ff.kind;
      s6_in.px   = s5_ff.px;
      s6_in.py   = s5_ff.py;
      s6_in.cx   = s5_ff.cx;
      s6_in.cy   = s5_ff.cy;
      s6_in.den  = s5_ff.den;
      s6_in.remx = NW'(s5_ff.unm) * NW'(s5_ff.magx);
      s6_in.remy = NW'(s5_ff.unm) * NW'(s5_ff.magy);
      s6_in.qx   = '0;
      s6_in.qy   = '0;
      s6_in.magx = s5_ff.magx;
      s6_in.magy = s5_ff.magy;
      s6_in.negx = s5_ff.negx;
      s6_in.negy = s5_ff.negy;
   end

   // Restoring division, most significant quotient bit first.
   for (genvar i = 0; i < QW; i++) begin : g_div
      if (i == 0) begin : g_first
         assign div_in[i] = div_step(s6_ff, QW - 1);
      end else begin : g_next
         assign div_in[i] = div_step(div_ff[i-1], QW - 1 - i);
      end
   end

   // Output: truncated offset added to C on a crossing.
   always_comb begin
      segx2d_pkg::div_type  d;
      logic signed [DW:0]   offx, offy;
      logic signed [CW-1:0] px, py;
      d    = div_ff[QW-1];
      offx = d.negx ? -$signed({1'b0, d.qx}) : $signed({1'b0, d.qx});
      offy = d.negy ? -$signed({1'b0, d.qy}) : $signed({1'b0, d.qy});
      px   = d.px;
      py   = d.py;
      if (d.kind == segx2d_pkg::KIND_CROSS) begin
         px = CW'((DW+1)'(d.cx) + offx);
         py = CW'((DW+1)'(d.cy) + offy);
      end
      rsp_tdata_in = {py, px};
      rsp_tuser_in = {d.kind, d.hit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         s3_vld_ff     <= 1'b0;
         s4_vld_ff     <= 1'b0;
         s5_vld_ff     <= 1'b0;
         s6_vld_ff     <= 1'b0;
         div_vld_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff     <= req_tvalid;
         s2_vld_ff     <= s1_vld_ff;
         s3_vld_ff     <= s2_vld_ff;
         s4_vld_ff     <= s3_vld_ff;
         s5_vld_ff     <= s4_vld_ff;
         s6_vld_ff     <= s5_vld_ff;
         div_vld_ff    <= {div_vld_ff[QW-2:0], s6_vld_ff};
         rsp_tvalid_ff <= div_vld_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
         s4_ff        <= s4_in;
         s5_ff        <= s5_in;
         s6_ff        <= s6_in;
         div_ff       <= div_in;
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tuser_ff[0] |->
         rsp_tuser_ff[2:1] == segx2d_pkg::KIND_MISS && rsp_tdata_ff == '0)
      else $error("miss result carries a nonzero kind or point");

   a_hit_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tuser_ff[0] |-> rsp_tuser_ff[2:1] != segx2d_pkg::KIND_MISS)
      else $error("hit result reports kind miss");

   a_quot_bound : assert property (@(posedge clock) disable iff (reset)
      div_vld_ff[QW-1] && div_ff[QW-1].kind == segx2d_pkg::KIND_CROSS |->
         div_ff[QW-1].qx <= div_ff[QW-1].magx && div_ff[QW-1].qy <= div_ff[QW-1].magy)
      else $error("crossing offset exceeds the length of CD");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid_ff)
      else $error("result valid right after reset");

endmodule
